// ----- rtl/core/slsub_pkg.sv -----
// ----------------------------------------------------------------------------
// slsub_pkg
// Shared constants for the visible-span list: default sizes and command codes.
// ----------------------------------------------------------------------------
package slsub_pkg;

	localparam int MAX_SPANS_DEF = 16;
	localparam int ROW_BITS_DEF  = 10;

	// storage word holds {bottom, top}
	localparam int RAM_W_DEF     = 2 * ROW_BITS_DEF;
	localparam int RAM_DEPTH_DEF = 2 * MAX_SPANS_DEF;

	localparam logic [1:0] CMD_START    = 2'd0;
	localparam logic [1:0] CMD_SUBTRACT = 2'd1;
	localparam logic [1:0] CMD_READOUT  = 2'd2;

	localparam int COUNT_OUT_W = 5;

endpackage

// ----- rtl/core/span_list_subtract.sv -----
// ----------------------------------------------------------------------------
// span_list_subtract
// Visible-span list: start, occluder subtraction with compaction, readout.
// ----------------------------------------------------------------------------
// Start: status result is valid in the cycle after the input transfer.
// Subtract: SUB_ADDR, a SUB_CMP step per stored span, a SUB_LOW step per span split
//   in two, then the status result; one compare step and one RAM write port per cycle.
// Readout: RD_ADDR, RD_DATA, then OUT per span; the next span is read once OUT is taken.
// The block takes no input while a command is in work or its result waits.
// arst_n clears the sequencer, count, overflow and bank; span RAM is not reset.
// ----------------------------------------------------------------------------
module span_list_subtract #(
	parameter int MAX_SPANS = slsub_pkg::MAX_SPANS_DEF,
	parameter int ROW_BITS  = slsub_pkg::ROW_BITS_DEF,
	localparam int IN_W     = ((2 * ROW_BITS + 7) / 8) * 8,
	localparam int OUT_W    = ((2 * ROW_BITS + slsub_pkg::COUNT_OUT_W + 2 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// span_bottom, span_top
	input  logic [IN_W-1:0]  s_axis_tdata,
	// command
	input  logic [1:0]       s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// out_bottom, out_top, span_count, empty_res, overflow
	output logic [OUT_W-1:0] m_axis_tdata,
	// is_span
	output logic             m_axis_tuser,
	output logic             m_axis_tlast
);

	localparam int IDX_W = $clog2(MAX_SPANS);
	localparam int CW    = $clog2(MAX_SPANS + 1);
	localparam int RW    = 2 * ROW_BITS;
	localparam int AW    = IDX_W + 1;
	localparam int PADW  = OUT_W - RW - slsub_pkg::COUNT_OUT_W - 2;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SUB_ADDR = 3'd1;
	localparam logic [2:0] ST_SUB_CMP  = 3'd2;
	localparam logic [2:0] ST_SUB_LOW  = 3'd3;
	localparam logic [2:0] ST_RD_ADDR  = 3'd4;
	localparam logic [2:0] ST_RD_DATA  = 3'd5;
	localparam logic [2:0] ST_OUT      = 3'd6;

	logic [2:0]          state_q;
	logic                bank_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       n_q;
	logic                ovf_q;
	logic [ROW_BITS-1:0] occ_bot_q;
	logic [ROW_BITS-1:0] occ_top_q;
	logic [ROW_BITS-1:0] low_bot_q;
	logic                is_span_q;
	logic                last_q;
	logic [ROW_BITS-1:0] out_bot_q;
	logic [ROW_BITS-1:0] out_top_q;

	logic                in_xfer;
	logic [ROW_BITS-1:0] in_bot;
	logic [ROW_BITS-1:0] in_top;
	logic [RW-1:0]       rd_data;
	logic [ROW_BITS-1:0] rd_bot;
	logic [ROW_BITS-1:0] rd_top;
	logic                miss;
	logic                above;
	logic                below;
	logic                push_en;
	logic [RW-1:0]       push_data;
	logic                has_room;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [RW-1:0]       wr_data;
	logic                adv;
	logic                go_low;
	logic [CW-1:0]       idx_inc;
	logic                idx_last;
	logic [CW-1:0]       n_nxt;
	logic [AW-1:0]       rd_addr;
	logic [31:0]         count_ext;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign in_bot   = s_axis_tdata[ROW_BITS-1:0];
	assign in_top   = s_axis_tdata[RW-1:ROW_BITS];
	assign rd_bot   = rd_data[RW-1:ROW_BITS];
	assign rd_top   = rd_data[ROW_BITS-1:0];
	assign idx_inc  = idx_q + CW'(1);
	assign idx_last = (idx_inc == count_q);
	assign has_room = (n_q != CW'(MAX_SPANS));

	// compare step for the span now on the read port
	assign miss  = (rd_bot < occ_top_q) || (rd_top > occ_bot_q);
	assign above = rd_top < occ_top_q;
	assign below = rd_bot > occ_bot_q;

	always_comb begin
		push_en   = 1'b0;
		push_data = {rd_bot, rd_top};
		adv       = 1'b0;
		go_low    = 1'b0;
		if (state_q == ST_SUB_CMP) begin
			if (miss) begin
				push_en = 1'b1;
				adv     = 1'b1;
			end else if (above) begin
				push_en   = 1'b1;
				push_data = {occ_top_q, rd_top};
				go_low    = below;
				adv       = !below;
			end else if (below) begin
				push_en   = 1'b1;
				push_data = {rd_bot, occ_bot_q};
				adv       = 1'b1;
			end else begin
				adv = 1'b1;
			end
		end else if (state_q == ST_SUB_LOW) begin
			push_en   = 1'b1;
			push_data = {low_bot_q, occ_bot_q};
			adv       = 1'b1;
		end
	end

	always_comb begin
		if (in_xfer && s_axis_tuser == slsub_pkg::CMD_START) begin
			wr_en   = 1'b1;
			wr_addr = {bank_q, IDX_W'(0)};
			wr_data = {in_bot, in_top};
		end else begin
			wr_en   = push_en && has_room;
			wr_addr = {!bank_q, n_q[IDX_W-1:0]};
			wr_data = push_data;
		end
	end

	assign n_nxt = wr_en ? n_q + CW'(1) : n_q;

	// look one span ahead when the current one finishes this cycle
	assign rd_addr = adv ? {bank_q, idx_inc[IDX_W-1:0]} : {bank_q, idx_q[IDX_W-1:0]};

	slsub_ram #(
		.WIDTH(RW),
		.DEPTH(2 ** AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bank_q  <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
			n_q     <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q) inside
				ST_IDLE: begin
					if (in_xfer) begin
						idx_q <= '0;
						n_q   <= '0;
						state_q <= ST_OUT;
						case (s_axis_tuser)
							slsub_pkg::CMD_START: begin
								count_q <= CW'(1);
								ovf_q   <= 1'b0;
							end
							slsub_pkg::CMD_SUBTRACT: begin
								if (count_q != '0) begin
									state_q <= ST_SUB_ADDR;
								end
							end
							slsub_pkg::CMD_READOUT: begin
								if (count_q != '0) begin
									state_q <= ST_RD_ADDR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SUB_ADDR: begin
					state_q <= ST_SUB_CMP;
				end
				ST_SUB_CMP, ST_SUB_LOW: begin
					n_q <= n_nxt;
					if (push_en && !has_room) begin
						ovf_q <= 1'b1;
					end
					if (go_low) begin
						state_q <= ST_SUB_LOW;
					end else if (idx_last) begin
						// swap banks: the new list becomes current
						bank_q  <= !bank_q;
						count_q <= n_nxt;
						state_q <= ST_OUT;
					end else begin
						idx_q   <= idx_inc;
						state_q <= ST_SUB_CMP;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_inc;
							state_q <= ST_RD_ADDR;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			occ_bot_q <= in_bot;
			occ_top_q <= in_top;
			is_span_q <= 1'b0;
			last_q    <= 1'b1;
			out_bot_q <= '0;
			out_top_q <= '0;
		end
		if (go_low) begin
			low_bot_q <= rd_bot;
		end
		if (state_q == ST_RD_DATA) begin
			is_span_q <= 1'b1;
			last_q    <= idx_last;
			out_bot_q <= rd_bot;
			out_top_q <= rd_top;
		end else if ((state_q == ST_SUB_CMP || state_q == ST_SUB_LOW) && !go_low && idx_last) begin
			is_span_q <= 1'b0;
			last_q    <= 1'b1;
			out_bot_q <= '0;
			out_top_q <= '0;
		end
	end

	assign count_ext     = 32'(count_q);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tuser  = is_span_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {PADW'(0), ovf_q, (count_q == '0),
		count_ext[slsub_pkg::COUNT_OUT_W-1:0], out_top_q, out_bot_q};

endmodule

// ----- rtl/core/slsub_ram.sv -----
// ----------------------------------------------------------------------------
// slsub_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slsub_ram #(
	parameter int WIDTH = slsub_pkg::RAM_W_DEF,
	parameter int DEPTH = slsub_pkg::RAM_DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
